// ----- src/sbm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types and constants for the SPI bus monitor.
// ----------------------------------------------------------------------------
package sbm_pkg;

   // bytes reported per packet; the byte counter holds at this value
   localparam int MAX_BYTES  = 64;
   localparam int BYTE_CNT_W = $clog2(MAX_BYTES + 1);

   localparam int IDX_W   = 6;
   localparam int LEN_W   = 7;
   localparam int BYTE_W  = 8;
   localparam int BIT_W   = 3;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_POLARITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_PHASE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MSB_FIRST      = 2'd2;

   typedef struct packed {
      logic chip_select_n;
      logic serial_clock;
      logic host_data;
      logic device_data;
   } sbm_req_type;

   typedef struct packed {
      logic              byte_valid;
      logic [BYTE_W-1:0] host_byte;
      logic [BYTE_W-1:0] device_byte;
      logic [IDX_W-1:0]  byte_index;
      logic              packet_end;
      logic [LEN_W-1:0]  packet_length;
      logic              host_setup_warn;
      logic              device_setup_warn;
   } sbm_rsp_type;

   typedef struct packed {
      logic clock_polarity;
      logic clock_phase;
      logic msb_first;
   } sbm_cfg_type;

endpackage

// ----- src/sbm_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_csr
// Configuration registers: clock mode and bit order.
// ----------------------------------------------------------------------------
module sbm_csr import sbm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output sbm_cfg_type           cfg
);

   sbm_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CLOCK_POLARITY: cfg_in.clock_polarity = csr_wdata[0];
            CSR_CLOCK_PHASE:    cfg_in.clock_phase    = csr_wdata[0];
            CSR_MSB_FIRST:      cfg_in.msb_first      = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_polarity <= 1'b0;
         cfg_ff.clock_phase    <= 1'b0;
         cfg_ff.msb_first      <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/sbm_req_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_req_reg
// Input register for pin samples; stalls only when full and not draining.
// ----------------------------------------------------------------------------
module sbm_req_reg import sbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  sbm_req_type req_data,
   input  logic        drain,      // result side takes the held sample
   output logic        held_valid,
   output sbm_req_type held_data
);

   logic        vld_ff, vld_in;
   sbm_req_type data_ff, data_in;
   logic        take;

   assign req_stall = vld_ff && !drain;
   assign take      = req_valid && !req_stall;
   assign vld_in    = take || (vld_ff && !drain);
   assign data_in   = take ? req_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign held_valid = vld_ff;
   assign held_data  = data_ff;

endmodule

// ----- src/sbm_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_decode
// Bus state tracking, edge detect, byte assembly and packet counting.
// ----------------------------------------------------------------------------
module sbm_decode import sbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  sbm_cfg_type cfg,
   input  logic        advance,    // sample consumed this cycle
   input  sbm_req_type sample,
   output sbm_rsp_type result
);

   logic                  last_sel_ff, last_sel_in;
   logic                  last_clk_ff, last_clk_in;
   logic                  last_hd_ff, last_hd_in;
   logic                  last_dd_ff, last_dd_in;
   logic [BIT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [BYTE_W-1:0]     host_sh_ff, host_sh_in;
   logic [BYTE_W-1:0]     dev_sh_ff, dev_sh_in;
   logic [BYTE_CNT_W-1:0] byte_cnt_ff, byte_cnt_in;

   logic              pkt_end, pkt_start, in_pkt, capture, byte_done, report;
   logic [BYTE_W-1:0] host_next, dev_next;

   assign pkt_end   = sample.chip_select_n && !last_sel_ff;
   assign pkt_start = !sample.chip_select_n && last_sel_ff;
   assign in_pkt    = !sample.chip_select_n && !last_sel_ff;
   // rising edge captures when CPOL == CPHA, falling edge otherwise
   assign capture   = in_pkt && (sample.serial_clock != last_clk_ff) &&
                      (sample.serial_clock == (cfg.clock_polarity == cfg.clock_phase));
   assign byte_done = capture && (bit_cnt_ff == {BIT_W{1'b1}});
   assign report    = byte_done && (byte_cnt_ff < BYTE_CNT_W'(MAX_BYTES));

   assign host_next = cfg.msb_first ? {host_sh_ff[BYTE_W-2:0], sample.host_data}
                                    : {sample.host_data, host_sh_ff[BYTE_W-1:1]};
   assign dev_next  = cfg.msb_first ? {dev_sh_ff[BYTE_W-2:0], sample.device_data}
                                    : {sample.device_data, dev_sh_ff[BYTE_W-1:1]};

   always_comb begin
      result                   = '0;
      result.byte_valid        = report;
      result.host_byte         = report ? host_next : '0;
      result.device_byte       = report ? dev_next : '0;
      result.byte_index        = report ? IDX_W'(byte_cnt_ff) : '0;
      result.packet_end        = pkt_end;
      result.packet_length     = pkt_end ? LEN_W'(byte_cnt_ff) : '0;
      result.host_setup_warn   = capture && (sample.host_data != last_hd_ff);
      result.device_setup_warn = capture && (sample.device_data != last_dd_ff);
   end

   always_comb begin
      last_sel_in = last_sel_ff;
      last_clk_in = last_clk_ff;
      last_hd_in  = last_hd_ff;
      last_dd_in  = last_dd_ff;
      bit_cnt_in  = bit_cnt_ff;
      host_sh_in  = host_sh_ff;
      dev_sh_in   = dev_sh_ff;
      byte_cnt_in = byte_cnt_ff;
      if (advance) begin
         last_sel_in = sample.chip_select_n;
         last_clk_in = sample.serial_clock;
         last_hd_in  = sample.host_data;
         last_dd_in  = sample.device_data;
         if (pkt_end) begin
            byte_cnt_in = '0;
         end else if (pkt_start) begin
            byte_cnt_in = '0;
            bit_cnt_in  = '0;
            host_sh_in  = '0;
            dev_sh_in   = '0;
         end else if (capture) begin
            bit_cnt_in = bit_cnt_ff + BIT_W'(1);
            host_sh_in = byte_done ? '0 : host_next;
            dev_sh_in  = byte_done ? '0 : dev_next;
            if (report) begin
               byte_cnt_in = byte_cnt_ff + BYTE_CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sel_ff <= 1'b1;
         last_clk_ff <= 1'b0;
         last_hd_ff  <= 1'b0;
         last_dd_ff  <= 1'b0;
         bit_cnt_ff  <= '0;
         host_sh_ff  <= '0;
         dev_sh_ff   <= '0;
         byte_cnt_ff <= '0;
      end else begin
         last_sel_ff <= last_sel_in;
         last_clk_ff <= last_clk_in;
         last_hd_ff  <= last_hd_in;
         last_dd_ff  <= last_dd_in;
         bit_cnt_ff  <= bit_cnt_in;
         host_sh_ff  <= host_sh_in;
         dev_sh_ff   <= dev_sh_in;
         byte_cnt_ff <= byte_cnt_in;
      end
   end

   a_byte_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      byte_cnt_ff <= BYTE_CNT_W'(MAX_BYTES))
      else $error("byte counter beyond limit");

   a_byte_clears_bits: assert property (@(posedge clock) disable iff (reset)
      advance && byte_done |=> bit_cnt_ff == '0 && host_sh_ff == '0 && dev_sh_ff == '0)
      else $error("byte completion did not clear assembly state");

   a_end_clears_count: assert property (@(posedge clock) disable iff (reset)
      advance && pkt_end |=> byte_cnt_ff == '0 && last_sel_ff)
      else $error("packet end did not clear byte count");

   a_report_counts: assert property (@(posedge clock) disable iff (reset)
      advance && report |=> byte_cnt_ff == $past(byte_cnt_ff) + BYTE_CNT_W'(1))
      else $error("reported byte not counted");

endmodule

// ----- src/sbm_rsp_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_rsp_reg
// Result register; holds a stalled response and frees up when taken.
// ----------------------------------------------------------------------------
module sbm_rsp_reg import sbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load_valid,
   input  sbm_rsp_type load_data,
   output logic        load_ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sbm_rsp_type rsp_data
);

   logic        vld_ff, vld_in;
   sbm_rsp_type data_ff, data_in;
   logic        load;

   assign load_ready = !vld_ff || !rsp_stall;
   assign load       = load_valid && load_ready;
   assign vld_in     = load || (vld_ff && rsp_stall);
   assign data_in    = load ? load_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- src/spi_bus_monitor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_bus_monitor_top
// Passive SPI bus monitor, clock modes 0 to 3, one pin sample per request.
//
//   channel  ports                         direction  carries
//   -------  ----------------------------  ---------  ------------------------
//   req      req_valid/req_stall/req_data  in         pin sample (cs, sck, data)
//   rsp      rsp_valid/rsp_stall/rsp_data  out        byte pair / packet end
//   csr      csr_we/csr_index/csr_wdata    in         CPOL, CPHA, bit order
//
// Each request yields exactly one response, via the input and output registers.
// Throughput is one request per clock while rsp_stall is low; the bus state
// update is a single register-to-register pass through sbm_decode.
// Synchronous active-high reset; the bus is taken as idle (chip select high).
// A stalled response holds in the output register; the input register still
// takes one more request, after which req_stall follows rsp_stall.
// ----------------------------------------------------------------------------
module spi_bus_monitor_top import sbm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // pin samples
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sbm_req_type           req_data,
   // results
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sbm_rsp_type           rsp_data,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   sbm_cfg_type cfg;
   logic        held_valid;
   sbm_req_type held_data;
   logic        load_ready;
   logic        advance;
   sbm_rsp_type result;

   // sample moves into decode state when the result register can take it
   assign advance = held_valid && load_ready;

   sbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sbm_req_reg u_req_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .drain      (advance),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   // edge detect, shift registers and counters; state steps on advance only
   sbm_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .sample  (held_data),
      .result  (result)
   );

   sbm_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (held_valid),
      .load_data  (result),
      .load_ready (load_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
